// File: rtl/hmb_pkg.sv
// Package with the shared types and codes of the host mailbox byte FIFOs.
`timescale 1ns / 1ps

package hmb_pkg;

    localparam logic [2:0] MODE_HOST_WRITE  = 3'd0;
    localparam logic [2:0] MODE_HOST_READ   = 3'd1;
    localparam logic [2:0] MODE_LOCAL_QUEUE = 3'd2;
    localparam logic [2:0] MODE_POP_BYTE    = 3'd3;
    localparam logic [2:0] MODE_POP_WORD    = 3'd4;
    localparam logic [2:0] MODE_POP_DOUBLE  = 3'd5;
    localparam logic [2:0] MODE_PEEK        = 3'd6;
    localparam logic [2:0] MODE_CLEAR       = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] data_in;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [7:0]  rx_count;
        logic        rx_empty;
        logic        host_ready;
        logic        overflow;
        logic        underflow;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RX_READ,
        ST_TX_CAPTURE,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic load;
        logic rx_write;
        logic tx_write;
        logic rx_read;
        logic rx_peek;
        logic rx_capture;
        logic tx_read;
        logic tx_capture;
        logic present_data;
        logic present_zero;
        logic latch_presented;
        logic set_ovf;
        logic set_unf;
        logic clear_ptrs;
    } cmd_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       rx_full;
        logic       tx_full;
        logic       tx_nonempty;
        logic       pending;
        logic       rx_has1;
        logic       rx_has2;
        logic       rx_has4;
    } stat_t;

endpackage

// File: rtl/hmb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module hmb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/hmb_datapath.sv
// Datapath of the mailbox: ring pointers, byte memories, output latch and result.
`timescale 1ns / 1ps

module hmb_datapath #(
    parameter int RING_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  hmb_pkg::req_t req,
    input  hmb_pkg::cmd_t cmd,
    output hmb_pkg::stat_t stat,
    output hmb_pkg::rsp_t rsp
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int FW = PW + 1;
    localparam logic [PW-1:0] PTR_LAST = PW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FILL_CAP = FW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FILL_DEPTH = FW'(RING_DEPTH);

    hmb_pkg::req_t req_reg;
    logic [PW-1:0] rx_wptr_reg, rx_wptr_next;
    logic [PW-1:0] rx_rptr_reg, rx_rptr_next;
    logic [PW-1:0] tx_wptr_reg, tx_wptr_next;
    logic [PW-1:0] tx_rptr_reg, tx_rptr_next;
    logic [7:0]    presented_reg, presented_next;
    logic          ready_reg, ready_next;
    logic          pending_reg, pending_next;
    logic [1:0]    cap_idx_reg, cap_idx_next;
    logic [31:0]   result_reg, result_next;
    logic          ovf_reg, ovf_next;
    logic          unf_reg, unf_next;

    logic [FW-1:0]   rx_fill;
    logic [FW-1:0]   tx_fill;
    logic [FW+7:0]   rx_fill_wide;
    logic [7:0]      rx_rdata;
    logic [7:0]      tx_rdata;

    always_comb
    begin
        if (rx_wptr_reg >= rx_rptr_reg)
        begin
            rx_fill = {1'b0, rx_wptr_reg} - {1'b0, rx_rptr_reg};
        end
        else
        begin
            rx_fill = {1'b0, rx_wptr_reg} + FILL_DEPTH - {1'b0, rx_rptr_reg};
        end
        if (tx_wptr_reg >= tx_rptr_reg)
        begin
            tx_fill = {1'b0, tx_wptr_reg} - {1'b0, tx_rptr_reg};
        end
        else
        begin
            tx_fill = {1'b0, tx_wptr_reg} + FILL_DEPTH - {1'b0, tx_rptr_reg};
        end
    end

    assign rx_fill_wide = (FW + 8)'(rx_fill);

    assign stat.mode        = req_reg.mode;
    assign stat.rx_full     = (rx_fill >= FILL_CAP);
    assign stat.tx_full     = (tx_fill >= FILL_CAP);
    assign stat.tx_nonempty = (tx_wptr_reg != tx_rptr_reg);
    assign stat.pending     = pending_reg;
    assign stat.rx_has1     = (rx_fill_wide >= (FW + 8)'(1));
    assign stat.rx_has2     = (rx_fill_wide >= (FW + 8)'(2));
    assign stat.rx_has4     = (rx_fill_wide >= (FW + 8)'(4));

    assign rsp.read_data  = result_reg;
    assign rsp.rx_count   = (rx_fill_wide > (FW + 8)'(255)) ? 8'hFF : rx_fill_wide[7:0];
    assign rsp.rx_empty   = (rx_fill == '0);
    assign rsp.host_ready = ready_reg;
    assign rsp.overflow   = ovf_reg;
    assign rsp.underflow  = unf_reg;

    hmb_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_rx_ram (
        .clk  (clk),
        .we   (cmd.rx_write),
        .waddr(rx_wptr_reg),
        .wdata(req_reg.data_in),
        .re   (cmd.rx_read | cmd.rx_peek),
        .raddr(rx_rptr_reg),
        .rdata(rx_rdata)
    );

    hmb_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_tx_ram (
        .clk  (clk),
        .we   (cmd.tx_write),
        .waddr(tx_wptr_reg),
        .wdata(req_reg.data_in),
        .re   (cmd.tx_read),
        .raddr(tx_rptr_reg),
        .rdata(tx_rdata)
    );

    always_comb
    begin
        rx_wptr_next   = rx_wptr_reg;
        rx_rptr_next   = rx_rptr_reg;
        tx_wptr_next   = tx_wptr_reg;
        tx_rptr_next   = tx_rptr_reg;
        presented_next = presented_reg;
        ready_next     = ready_reg;
        pending_next   = pending_reg;
        cap_idx_next   = cap_idx_reg;
        result_next    = result_reg;
        ovf_next       = ovf_reg;
        unf_next       = unf_reg;

        if (cmd.load)
        begin
            cap_idx_next = 2'd0;
            result_next  = 32'd0;
            ovf_next     = 1'b0;
            unf_next     = 1'b0;
        end
        if (cmd.rx_write)
        begin
            rx_wptr_next = (rx_wptr_reg == PTR_LAST) ? '0 : rx_wptr_reg + 1'b1;
        end
        if (cmd.tx_write)
        begin
            tx_wptr_next = (tx_wptr_reg == PTR_LAST) ? '0 : tx_wptr_reg + 1'b1;
        end
        if (cmd.rx_read)
        begin
            rx_rptr_next = (rx_rptr_reg == PTR_LAST) ? '0 : rx_rptr_reg + 1'b1;
        end
        if (cmd.tx_read)
        begin
            tx_rptr_next = (tx_rptr_reg == PTR_LAST) ? '0 : tx_rptr_reg + 1'b1;
        end
        if (cmd.rx_capture)
        begin
            result_next[{cap_idx_reg, 3'b000} +: 8] = rx_rdata;
            cap_idx_next = cap_idx_reg + 2'd1;
        end
        if (cmd.latch_presented)
        begin
            result_next = {24'd0, presented_reg};
        end
        if (cmd.tx_capture)
        begin
            presented_next = tx_rdata;
            if (tx_wptr_reg == tx_rptr_reg)
            begin
                pending_next = 1'b0;
            end
        end
        if (cmd.present_zero)
        begin
            presented_next = 8'd0;
            ready_next     = 1'b0;
            pending_next   = 1'b0;
        end
        if (cmd.present_data)
        begin
            presented_next = req_reg.data_in;
            ready_next     = 1'b1;
            pending_next   = 1'b1;
        end
        if (cmd.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.set_unf)
        begin
            unf_next = 1'b1;
        end
        if (cmd.clear_ptrs)
        begin
            rx_wptr_next = '0;
            rx_rptr_next = '0;
            tx_wptr_next = '0;
            tx_rptr_next = '0;
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_wptr_reg   <= '0;
            rx_rptr_reg   <= '0;
            tx_wptr_reg   <= '0;
            tx_rptr_reg   <= '0;
            presented_reg <= 8'd0;
            ready_reg     <= 1'b0;
            pending_reg   <= 1'b0;
            cap_idx_reg   <= 2'd0;
        end
        else
        begin
            rx_wptr_reg   <= rx_wptr_next;
            rx_rptr_reg   <= rx_rptr_next;
            tx_wptr_reg   <= tx_wptr_next;
            tx_rptr_reg   <= tx_rptr_next;
            presented_reg <= presented_next;
            ready_reg     <= ready_next;
            pending_reg   <= pending_next;
            cap_idx_reg   <= cap_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        result_reg <= result_next;
        ovf_reg    <= ovf_next;
        unf_reg    <= unf_next;
    end

endmodule

// File: rtl/hmb_ctrl.sv
// Controller state machine that sequences each mailbox request.
`timescale 1ns / 1ps

module hmb_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  hmb_pkg::stat_t stat,
    output logic           busy,
    output logic           done,
    output hmb_pkg::cmd_t  cmd
);

    hmb_pkg::state_t state_reg, state_next;
    logic [1:0] issue_left_reg, issue_left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hmb_pkg::ST_IDLE;
            issue_left_reg <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_left_reg <= issue_left_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        issue_left_next = issue_left_reg;
        cmd             = '0;
        busy            = 1'b1;
        done            = 1'b0;

        case (state_reg)
            hmb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = hmb_pkg::ST_DECODE;
                end
            end

            hmb_pkg::ST_DECODE:
            begin
                state_next = hmb_pkg::ST_RESPOND;
                case (stat.mode)
                    hmb_pkg::MODE_HOST_WRITE:
                    begin
                        if (stat.rx_full)
                        begin
                            cmd.set_ovf = 1'b1;
                        end
                        else
                        begin
                            cmd.rx_write = 1'b1;
                        end
                    end
                    hmb_pkg::MODE_HOST_READ:
                    begin
                        cmd.latch_presented = 1'b1;
                        if (stat.tx_nonempty)
                        begin
                            cmd.tx_read = 1'b1;
                            state_next  = hmb_pkg::ST_TX_CAPTURE;
                        end
                        else
                        begin
                            cmd.present_zero = 1'b1;
                        end
                    end
                    hmb_pkg::MODE_LOCAL_QUEUE:
                    begin
                        if (!stat.pending)
                        begin
                            cmd.present_data = 1'b1;
                        end
                        else if (stat.tx_full)
                        begin
                            cmd.set_ovf = 1'b1;
                        end
                        else
                        begin
                            cmd.tx_write = 1'b1;
                        end
                    end
                    hmb_pkg::MODE_POP_BYTE:
                    begin
                        if (!stat.rx_has1)
                        begin
                            cmd.set_unf = 1'b1;
                        end
                        else
                        begin
                            cmd.rx_read     = 1'b1;
                            issue_left_next = 2'd0;
                            state_next      = hmb_pkg::ST_RX_READ;
                        end
                    end
                    hmb_pkg::MODE_POP_WORD:
                    begin
                        if (!stat.rx_has2)
                        begin
                            cmd.set_unf = 1'b1;
                        end
                        else
                        begin
                            cmd.rx_read     = 1'b1;
                            issue_left_next = 2'd1;
                            state_next      = hmb_pkg::ST_RX_READ;
                        end
                    end
                    hmb_pkg::MODE_POP_DOUBLE:
                    begin
                        if (!stat.rx_has4)
                        begin
                            cmd.set_unf = 1'b1;
                        end
                        else
                        begin
                            cmd.rx_read     = 1'b1;
                            issue_left_next = 2'd3;
                            state_next      = hmb_pkg::ST_RX_READ;
                        end
                    end
                    hmb_pkg::MODE_PEEK:
                    begin
                        if (!stat.rx_has1)
                        begin
                            cmd.set_unf = 1'b1;
                        end
                        else
                        begin
                            cmd.rx_peek     = 1'b1;
                            issue_left_next = 2'd0;
                            state_next      = hmb_pkg::ST_RX_READ;
                        end
                    end
                    default:
                    begin
                        cmd.clear_ptrs = 1'b1;
                    end
                endcase
            end

            hmb_pkg::ST_RX_READ:
            begin
                cmd.rx_capture = 1'b1;
                if (issue_left_reg != 2'd0)
                begin
                    cmd.rx_read     = 1'b1;
                    issue_left_next = issue_left_reg - 2'd1;
                end
                else
                begin
                    state_next = hmb_pkg::ST_RESPOND;
                end
            end

            hmb_pkg::ST_TX_CAPTURE:
            begin
                cmd.tx_capture = 1'b1;
                state_next     = hmb_pkg::ST_RESPOND;
            end

            hmb_pkg::ST_RESPOND:
            begin
                done       = 1'b1;
                state_next = hmb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = hmb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/host_mailbox_byte_fifos.sv
// Top level of the host mailbox with one byte FIFO in each direction.
//
//   Channel   Handshake            Payload
//   request   start, busy          req  (mode, data_in)
//   result    done (one cycle)     rsp  (read_data, rx_count, rx_empty, host_ready,
//                                        overflow, underflow)
//
// A request is taken when start is high and busy is low, and its result is shown
// with done for one cycle. Each request passes the decode and respond states; a
// host read that reloads from the transmit ring adds the capture state, and a pop
// or peek adds one receive read step per byte, set by the single read port of the
// receive memory. Reset empties both rings and clears the output latch and ready
// flag. The receiver cannot stall the result; busy stays high until done is shown.
`timescale 1ns / 1ps

module host_mailbox_byte_fifos #(
    parameter int RING_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  hmb_pkg::req_t req,
    output logic          done,
    output hmb_pkg::rsp_t rsp
);

    hmb_pkg::cmd_t  cmd;
    hmb_pkg::stat_t stat;

    hmb_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .busy (busy),
        .done (done),
        .cmd  (cmd)
    );

    hmb_datapath #(
        .RING_DEPTH(RING_DEPTH)
    ) u_datapath (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .cmd  (cmd),
        .stat (stat),
        .rsp  (rsp)
    );

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the host mailbox byte FIFOs with random pacing.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH = 256;
    localparam int LIMIT = 400000;

    typedef enum int {PROF_MIXED, PROF_RX_FILL, PROF_TX_FILL, PROF_DRAIN} profile_t;

    class mailbox_predictor;
        logic [7:0] rx_mem [DEPTH];
        logic [7:0] tx_mem [DEPTH];
        logic [7:0] rx_wp, rx_rp, tx_wp, tx_rp, latch;
        bit         ready, pending;
        hmb_pkg::rsp_t expected_q [$];
        int         errors, requests, overflows, underflows, clears;

        function new();
            rx_wp = 8'd0;
            rx_rp = 8'd0;
            tx_wp = 8'd0;
            tx_rp = 8'd0;
            latch = 8'd0;
            ready = 1'b0;
            pending = 1'b0;
            errors = 0;
            requests = 0;
            overflows = 0;
            underflows = 0;
            clears = 0;
        endfunction

        function logic [7:0] rx_take();
            logic [7:0] v;
            v = rx_mem[rx_rp];
            rx_rp = rx_rp + 8'd1;
            return v;
        endfunction

        function void note(hmb_pkg::req_t r);
            logic [31:0] value;
            logic [7:0]  rx_fill, tx_fill, b0, b1, b2, b3;
            bit          ovf, unf;
            hmb_pkg::rsp_t e;
            value = 32'd0;
            ovf = 1'b0;
            unf = 1'b0;
            rx_fill = rx_wp - rx_rp;
            tx_fill = tx_wp - tx_rp;
            case (r.mode)
                hmb_pkg::MODE_HOST_WRITE:
                    if (rx_fill == 8'd255)
                        ovf = 1'b1;
                    else
                    begin
                        rx_mem[rx_wp] = r.data_in;
                        rx_wp = rx_wp + 8'd1;
                    end
                hmb_pkg::MODE_HOST_READ:
                begin
                    value = {24'd0, latch};
                    if (tx_wp != tx_rp)
                    begin
                        latch = tx_mem[tx_rp];
                        tx_rp = tx_rp + 8'd1;
                    end
                    else
                    begin
                        latch = 8'd0;
                        ready = 1'b0;
                    end
                    if (tx_wp == tx_rp)
                        pending = 1'b0;
                end
                hmb_pkg::MODE_LOCAL_QUEUE:
                    if (!pending)
                    begin
                        latch = r.data_in;
                        pending = 1'b1;
                        ready = 1'b1;
                    end
                    else if (tx_fill == 8'd255)
                        ovf = 1'b1;
                    else
                    begin
                        tx_mem[tx_wp] = r.data_in;
                        tx_wp = tx_wp + 8'd1;
                    end
                hmb_pkg::MODE_POP_BYTE:
                    if (rx_fill < 8'd1)
                        unf = 1'b1;
                    else
                        value = {24'd0, rx_take()};
                hmb_pkg::MODE_POP_WORD:
                    if (rx_fill < 8'd2)
                        unf = 1'b1;
                    else
                    begin
                        b0 = rx_take();
                        b1 = rx_take();
                        value = {16'd0, b1, b0};
                    end
                hmb_pkg::MODE_POP_DOUBLE:
                    if (rx_fill < 8'd4)
                        unf = 1'b1;
                    else
                    begin
                        b0 = rx_take();
                        b1 = rx_take();
                        b2 = rx_take();
                        b3 = rx_take();
                        value = {b3, b2, b1, b0};
                    end
                hmb_pkg::MODE_PEEK:
                    if (rx_fill < 8'd1)
                        unf = 1'b1;
                    else
                        value = {24'd0, rx_mem[rx_rp]};
                default:
                begin
                    rx_wp = 8'd0;
                    rx_rp = 8'd0;
                    tx_wp = 8'd0;
                    tx_rp = 8'd0;
                    pending = 1'b0;
                    clears++;
                end
            endcase
            rx_fill = rx_wp - rx_rp;
            e.read_data = value;
            e.rx_count = rx_fill;
            e.rx_empty = (rx_fill == 8'd0);
            e.host_ready = ready;
            e.overflow = ovf;
            e.underflow = unf;
            expected_q.push_back(e);
            requests++;
            overflows += ovf;
            underflows += unf;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 30)
                $display("ERROR at %0t: %s", $time, what);
        endtask

        task check(hmb_pkg::rsp_t got);
            hmb_pkg::rsp_t e;
            if (expected_q.size() == 0)
            begin
                report("result strobe with no request outstanding");
                return;
            end
            e = expected_q.pop_front();
            if (got.read_data !== e.read_data)
                report($sformatf("read_data %h, expected %h", got.read_data, e.read_data));
            if (got.rx_count !== e.rx_count)
                report($sformatf("rx_count %0d, expected %0d", got.rx_count, e.rx_count));
            if (got.rx_empty !== e.rx_empty)
                report($sformatf("rx_empty %b, expected %b", got.rx_empty, e.rx_empty));
            if (got.host_ready !== e.host_ready)
                report($sformatf("host_ready %b, expected %b", got.host_ready, e.host_ready));
            if (got.overflow !== e.overflow)
                report($sformatf("overflow %b, expected %b", got.overflow, e.overflow));
            if (got.underflow !== e.underflow)
                report($sformatf("underflow %b, expected %b", got.underflow, e.underflow));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    hmb_pkg::req_t req;
    hmb_pkg::rsp_t rsp;

    mailbox_predictor tracker = new();
    int idle_pct;
    int cycles;

    host_mailbox_byte_fifos dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("Timeout after %0d cycles.", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check(rsp);
    end

    task automatic send_request(input logic [2:0] mode, input logic [7:0] data);
        hmb_pkg::req_t r;
        r.mode = mode;
        r.data_in = data;
        req <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note(r);
    endtask

    task automatic idle_gap();
        int n;
        n = 0;
        while (n < 30 && $urandom_range(99) < idle_pct)
            n++;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_all_answered();
        start <= 1'b0;
        while (tracker.expected_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [2:0] pick_mode(profile_t p);
        int roll;
        roll = $urandom_range(99);
        case (p)
            PROF_RX_FILL:
                if (roll < 88) return hmb_pkg::MODE_HOST_WRITE;
                else if (roll < 92) return hmb_pkg::MODE_PEEK;
                else if (roll < 96) return hmb_pkg::MODE_HOST_READ;
                else return hmb_pkg::MODE_LOCAL_QUEUE;
            PROF_TX_FILL:
                if (roll < 88) return hmb_pkg::MODE_LOCAL_QUEUE;
                else if (roll < 93) return hmb_pkg::MODE_HOST_WRITE;
                else return hmb_pkg::MODE_PEEK;
            PROF_DRAIN:
                if (roll < 25) return hmb_pkg::MODE_POP_BYTE;
                else if (roll < 45) return hmb_pkg::MODE_POP_WORD;
                else if (roll < 65) return hmb_pkg::MODE_POP_DOUBLE;
                else if (roll < 85) return hmb_pkg::MODE_HOST_READ;
                else if (roll < 95) return hmb_pkg::MODE_PEEK;
                else return hmb_pkg::MODE_HOST_WRITE;
            default:
                if (roll < 22) return hmb_pkg::MODE_HOST_WRITE;
                else if (roll < 36) return hmb_pkg::MODE_HOST_READ;
                else if (roll < 54) return hmb_pkg::MODE_LOCAL_QUEUE;
                else if (roll < 66) return hmb_pkg::MODE_POP_BYTE;
                else if (roll < 76) return hmb_pkg::MODE_POP_WORD;
                else if (roll < 86) return hmb_pkg::MODE_POP_DOUBLE;
                else if (roll < 98) return hmb_pkg::MODE_PEEK;
                else return hmb_pkg::MODE_CLEAR;
        endcase
    endfunction

    task automatic run_block(input profile_t p, input int count);
        for (int i = 0; i < count; i++)
        begin
            idle_gap();
            send_request(pick_mode(p), 8'($urandom_range(255)));
        end
    endtask

    logic [2:0] dir_mode [25] = '{
        hmb_pkg::MODE_POP_BYTE, hmb_pkg::MODE_POP_WORD, hmb_pkg::MODE_POP_DOUBLE,
        hmb_pkg::MODE_PEEK, hmb_pkg::MODE_HOST_READ, hmb_pkg::MODE_HOST_WRITE,
        hmb_pkg::MODE_POP_WORD, hmb_pkg::MODE_HOST_WRITE, hmb_pkg::MODE_HOST_WRITE,
        hmb_pkg::MODE_POP_DOUBLE, hmb_pkg::MODE_PEEK, hmb_pkg::MODE_POP_WORD,
        hmb_pkg::MODE_HOST_WRITE, hmb_pkg::MODE_HOST_WRITE, hmb_pkg::MODE_HOST_WRITE,
        hmb_pkg::MODE_POP_DOUBLE, hmb_pkg::MODE_POP_BYTE, hmb_pkg::MODE_LOCAL_QUEUE,
        hmb_pkg::MODE_LOCAL_QUEUE, hmb_pkg::MODE_HOST_READ, hmb_pkg::MODE_HOST_READ,
        hmb_pkg::MODE_HOST_READ, hmb_pkg::MODE_LOCAL_QUEUE, hmb_pkg::MODE_CLEAR,
        hmb_pkg::MODE_HOST_READ
    };
    logic [7:0] dir_data [25] = '{
        8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
        8'h00, 8'hFF, 8'hFF, 8'hA5, 8'h00,
        8'hFF, 8'h00, 8'h5A, 8'h81, 8'h7E,
        8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF,
        8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF
    };

    initial
    begin
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty-ring underflows, partial pops, latch reload and clear behavior.
        for (int i = 0; i < 25; i++)
            send_request(dir_mode[i], dir_data[i]);
        wait_all_answered();

        idle_pct = 0;
        run_block(PROF_MIXED, 250);
        run_block(PROF_RX_FILL, 300);
        wait_all_answered();

        idle_pct = 81;
        run_block(PROF_DRAIN, 200);
        run_block(PROF_TX_FILL, 320);
        wait_all_answered();

        idle_pct = 17;
        run_block(PROF_MIXED, 300);
        run_block(PROF_DRAIN, 150);
        wait_all_answered();

        idle_pct = 0;
        run_block(PROF_MIXED, 380);
        wait_all_answered();
        repeat (10) @(posedge clk);

        $display("Ran %0d requests over four pacing phases with ring fill and drain runs.",
                 tracker.requests);
        $display("Saw %0d overflows, %0d underflows and %0d clears; %0d mismatches.",
                 tracker.overflows, tracker.underflows, tracker.clears, tracker.errors);
        if (tracker.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: host_mailbox_byte_fifos.f
rtl/hmb_pkg.sv
rtl/hmb_ram.sv
rtl/hmb_datapath.sv
rtl/hmb_ctrl.sv
rtl/host_mailbox_byte_fifos.sv
bench/tb_top.sv
